FILE: sv/lca_binary_lifting_engine_defines.svh
// ----------------------------------------------------------------------------
// lca_binary_lifting_engine_defines.svh
// Assertion macros shared by the checkers of the LCA engine.
// ----------------------------------------------------------------------------
`ifndef LCA_BINARY_LIFTING_ENGINE_DEFINES_SVH
`define LCA_BINARY_LIFTING_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define LCABL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define LCABL_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/lcabl_pkg.sv
// ----------------------------------------------------------------------------
// lcabl_pkg
// Types, constants and control groups of the binary-lifting LCA engine.
// ----------------------------------------------------------------------------
package lcabl_pkg;

  localparam int NODE_W     = 10;
  localparam int DEPTH_W    = 10;
  localparam int LVL_W      = 4;
  localparam int NODES_DEF  = 1024;
  localparam int LEVELS_DEF = 10;

  typedef logic [NODE_W-1:0]  node_t;
  typedef logic [DEPTH_W-1:0] depth_t;
  typedef logic [LVL_W-1:0]   lvl_t;

  localparam depth_t DEPTH_MAX = depth_t'(1023);

  // Transaction function codes
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // Ancestor store write and read requests
  typedef struct packed {
    logic  en;
    node_t node;
    lvl_t  lvl;
    node_t data;
  } anc_wr_t;

  typedef struct packed {
    node_t node;
    lvl_t  lvl;
  } anc_rd_t;

  // Depth store write request
  typedef struct packed {
    logic   en;
    node_t  node;
    depth_t data;
  } dep_wr_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LD_WALK,
    ST_Q_ORD,
    ST_Q_UP,
    ST_Q_CMP,
    ST_Q_EQ,
    ST_Q_LIFT,
    ST_Q_PAR,
    ST_Q_OUT
  } state_t;

endpackage

FILE: sv/lcabl_if.sv
// ----------------------------------------------------------------------------
// lcabl_if
// Valid/ready channels of the LCA engine: item input and result output.
// ----------------------------------------------------------------------------
interface lcabl_in_if import lcabl_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  func;
  node_t node_a;
  node_t node_b;

  modport source(output valid, func, node_a, node_b, input ready);
  modport sink(input valid, func, node_a, node_b, output ready);
endinterface

interface lcabl_out_if import lcabl_pkg::*; ();
  logic   valid;
  logic   ready;
  node_t  lca_node;
  depth_t lca_depth;

  modport source(output valid, lca_node, lca_depth, input ready);
  modport sink(input valid, lca_node, lca_depth, output ready);
endinterface

FILE: sv/lcabl_anc_mem.sv
// ----------------------------------------------------------------------------
// lcabl_anc_mem
// Ancestor store: one row of LEVELS node numbers per node, one write port,
// two registered read ports. Node 0 reads as all zero; a read of the entry
// written in the same cycle returns the new data.
// ----------------------------------------------------------------------------
module lcabl_anc_mem import lcabl_pkg::*; #(
  parameter int NODES  = NODES_DEF,
  parameter int LEVELS = LEVELS_DEF
) (
  input  logic    clk,
  input  anc_wr_t wr,
  input  anc_rd_t rd_a,
  input  anc_rd_t rd_b,
  output node_t   q_a,
  output node_t   q_b
);

  localparam int NW   = $clog2(NODES);
  localparam int LW   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int AW   = NW + LW;
  localparam int ROWS = NODES * (2 ** LW);

  node_t         anc_mem [ROWS];
  logic [AW-1:0] wa;
  logic [AW-1:0] ra_a;
  logic [AW-1:0] ra_b;
  node_t         q_a_r;
  node_t         q_b_r;
  node_t         wd_r;
  logic          zero_a_r;
  logic          zero_b_r;
  logic          fwd_a_r;
  logic          fwd_b_r;

  // Form row-major addresses: node in the upper bits, level in the lower
  assign wa   = {NW'(wr.node), LW'(wr.lvl)};
  assign ra_a = {NW'(rd_a.node), LW'(rd_a.lvl)};
  assign ra_b = {NW'(rd_b.node), LW'(rd_b.lvl)};

  // Write, read and capture bypass flags
  always_ff @(posedge clk) begin
    if (wr.en) begin
      anc_mem[wa] <= wr.data;
    end
    q_a_r    <= anc_mem[ra_a];
    q_b_r    <= anc_mem[ra_b];
    wd_r     <= wr.data;
    zero_a_r <= (rd_a.node == '0);
    zero_b_r <= (rd_b.node == '0);
    fwd_a_r  <= wr.en && (wa == ra_a);
    fwd_b_r  <= wr.en && (wa == ra_b);
  end

  // Mask the sentinel row, forward same-cycle writes
  assign q_a = zero_a_r ? '0 : (fwd_a_r ? wd_r : q_a_r);
  assign q_b = zero_b_r ? '0 : (fwd_b_r ? wd_r : q_b_r);

endmodule

FILE: sv/lcabl_dep_mem.sv
// ----------------------------------------------------------------------------
// lcabl_dep_mem
// Depth store: one depth per node, one write port, two registered read
// ports. Node 0 reads as depth zero.
// ----------------------------------------------------------------------------
module lcabl_dep_mem import lcabl_pkg::*; #(
  parameter int NODES = NODES_DEF
) (
  input  logic    clk,
  input  dep_wr_t wr,
  input  node_t   rd_a,
  input  node_t   rd_b,
  output depth_t  q_a,
  output depth_t  q_b
);

  localparam int NW = $clog2(NODES);

  depth_t dep_mem [NODES];
  depth_t q_a_r;
  depth_t q_b_r;
  logic   zero_a_r;
  logic   zero_b_r;

  // Write and read
  always_ff @(posedge clk) begin
    if (wr.en) begin
      dep_mem[NW'(wr.node)] <= wr.data;
    end
    q_a_r    <= dep_mem[NW'(rd_a)];
    q_b_r    <= dep_mem[NW'(rd_b)];
    zero_a_r <= (rd_a == '0);
    zero_b_r <= (rd_b == '0);
  end

  // Mask the sentinel node
  assign q_a = zero_a_r ? '0 : q_a_r;
  assign q_b = zero_b_r ? '0 : q_b_r;

endmodule

FILE: sv/lcabl_seq.sv
// ----------------------------------------------------------------------------
// lcabl_seq
// Sequencer of the LCA engine: walks the ancestor levels of a load, lifts
// the two nodes of a query, and holds the result in an output register.
// ----------------------------------------------------------------------------
module lcabl_seq import lcabl_pkg::*; #(
  parameter int NODES  = NODES_DEF,
  parameter int LEVELS = LEVELS_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  logic    in_func,
  input  node_t   in_node_a,
  input  node_t   in_node_b,
  output logic    out_valid,
  input  logic    out_ready,
  output node_t   out_lca_node,
  output depth_t  out_lca_depth,
  output anc_wr_t anc_wr,
  output anc_rd_t anc_rd_a,
  output anc_rd_t anc_rd_b,
  input  node_t   anc_q_a,
  input  node_t   anc_q_b,
  output dep_wr_t dep_wr,
  output node_t   dep_rd_a,
  output node_t   dep_rd_b,
  input  depth_t  dep_q_a,
  input  depth_t  dep_q_b
);

  localparam logic [31:0] NODES_U   = 32'(NODES);
  localparam lvl_t        LAST_LVL  = lvl_t'(LEVELS - 1);
  localparam logic        MULTI_LVL = (LEVELS > 1);

  state_t state_r, state_nxt;
  node_t  x_r, x_nxt;
  node_t  y_r, y_nxt;
  node_t  up_r, up_nxt;
  node_t  l_r, l_nxt;
  depth_t dy_r, dy_nxt;
  lvl_t   lvl_r, lvl_nxt;
  logic   out_valid_r, out_valid_nxt;
  node_t  out_node_r, out_node_nxt;
  depth_t out_depth_r, out_depth_nxt;

  node_t  a_cl;
  node_t  b_cl;
  logic   in_acc;
  logic   push_ok;
  logic   swap;
  node_t  xn;
  node_t  yn;

  // Treat out-of-range node numbers as the sentinel
  assign a_cl = (32'(in_node_a) < NODES_U) ? in_node_a : '0;
  assign b_cl = (32'(in_node_b) < NODES_U) ? in_node_b : '0;

  assign in_ready      = (state_r == ST_IDLE);
  assign in_acc        = in_valid && in_ready;
  assign push_ok       = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_lca_node  = out_node_r;
  assign out_lca_depth = out_depth_r;

  // Advance state and hold working registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    x_r         <= x_nxt;
    y_r         <= y_nxt;
    up_r        <= up_nxt;
    l_r         <= l_nxt;
    dy_r        <= dy_nxt;
    lvl_r       <= lvl_nxt;
    out_node_r  <= out_node_nxt;
    out_depth_r <= out_depth_nxt;
  end

  // Next state, memory requests and result push
  always_comb begin
    state_nxt     = state_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    up_nxt        = up_r;
    l_nxt         = l_r;
    dy_nxt        = dy_r;
    lvl_nxt       = lvl_r;
    out_node_nxt  = out_node_r;
    out_depth_nxt = out_depth_r;
    out_valid_nxt = out_valid_r && !out_ready;
    anc_wr        = '0;
    anc_rd_a      = '{node: x_r, lvl: lvl_r};
    anc_rd_b      = '{node: y_r, lvl: lvl_r};
    dep_wr        = '0;
    dep_rd_a      = x_r;
    dep_rd_b      = y_r;
    swap          = 1'b0;
    xn            = x_r;
    yn            = y_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_func == FUNC_QUERY)) begin
          dep_rd_a  = a_cl;
          dep_rd_b  = b_cl;
          x_nxt     = a_cl;
          y_nxt     = b_cl;
          state_nxt = ST_Q_ORD;
        end else if (in_acc && (a_cl != '0)) begin
          // Write level 0, start the walk from the parent
          anc_wr    = '{en: 1'b1, node: a_cl, lvl: '0, data: b_cl};
          anc_rd_a  = '{node: b_cl, lvl: '0};
          dep_rd_a  = b_cl;
          x_nxt     = a_cl;
          lvl_nxt   = lvl_t'(1);
          state_nxt = ST_LD_WALK;
        end
      end

      ST_LD_WALK: begin
        if (lvl_r == lvl_t'(1)) begin
          dep_wr = '{en: 1'b1, node: x_r,
                     data: (dep_q_a == DEPTH_MAX) ? DEPTH_MAX : dep_q_a + depth_t'(1)};
        end
        if (MULTI_LVL) begin
          anc_wr   = '{en: 1'b1, node: x_r, lvl: lvl_r, data: anc_q_a};
          anc_rd_a = '{node: anc_q_a, lvl: lvl_r};
        end
        if (lvl_r >= LAST_LVL) begin
          state_nxt = ST_IDLE;
        end else begin
          lvl_nxt = lvl_r + lvl_t'(1);
        end
      end

      ST_Q_ORD: begin
        // Make x the deeper node
        swap      = (dep_q_a < dep_q_b);
        xn        = swap ? y_r : x_r;
        yn        = swap ? x_r : y_r;
        x_nxt     = xn;
        y_nxt     = yn;
        dy_nxt    = swap ? dep_q_a : dep_q_b;
        anc_rd_a  = '{node: xn, lvl: LAST_LVL};
        lvl_nxt   = LAST_LVL;
        state_nxt = ST_Q_UP;
      end

      ST_Q_UP: begin
        up_nxt    = anc_q_a;
        dep_rd_a  = anc_q_a;
        state_nxt = ST_Q_CMP;
      end

      ST_Q_CMP: begin
        // Lift x while it stays at or below the depth of y
        xn    = (dep_q_a >= dy_r) ? up_r : x_r;
        x_nxt = xn;
        if (lvl_r == '0) begin
          state_nxt = ST_Q_EQ;
        end else begin
          lvl_nxt   = lvl_r - lvl_t'(1);
          anc_rd_a  = '{node: xn, lvl: lvl_r - lvl_t'(1)};
          state_nxt = ST_Q_UP;
        end
      end

      ST_Q_EQ: begin
        if (x_r == y_r) begin
          l_nxt     = x_r;
          dep_rd_a  = x_r;
          state_nxt = ST_Q_OUT;
        end else begin
          anc_rd_a  = '{node: x_r, lvl: LAST_LVL};
          anc_rd_b  = '{node: y_r, lvl: LAST_LVL};
          lvl_nxt   = LAST_LVL;
          state_nxt = ST_Q_LIFT;
        end
      end

      ST_Q_LIFT: begin
        // Lift both while their ancestors differ
        if (anc_q_a != anc_q_b) begin
          xn = anc_q_a;
          yn = anc_q_b;
        end
        x_nxt = xn;
        y_nxt = yn;
        if (lvl_r == '0) begin
          anc_rd_a  = '{node: xn, lvl: '0};
          state_nxt = ST_Q_PAR;
        end else begin
          lvl_nxt   = lvl_r - lvl_t'(1);
          anc_rd_a  = '{node: xn, lvl: lvl_r - lvl_t'(1)};
          anc_rd_b  = '{node: yn, lvl: lvl_r - lvl_t'(1)};
        end
      end

      ST_Q_PAR: begin
        l_nxt     = anc_q_a;
        dep_rd_a  = anc_q_a;
        state_nxt = ST_Q_OUT;
      end

      ST_Q_OUT: begin
        // Keep the depth read addressed until the output register frees up
        dep_rd_a = l_r;
        if (push_ok) begin
          out_valid_nxt = 1'b1;
          out_node_nxt  = l_r;
          out_depth_nxt = dep_q_a;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/lca_binary_lifting_engine.sv
// ----------------------------------------------------------------------------
// lca_binary_lifting_engine
// Lowest common ancestor engine over a binary-lifting ancestor table.
// ----------------------------------------------------------------------------
// Items are processed one at a time; in_ch.ready is high only while the
// engine is idle. A load fills the node's levels one after another, bounded
// by the chain of dependent reads through the single ancestor read port used
// to fill them; a load of node 0 is dropped and gives no result. A query
// first lifts the deeper node level by level (ancestor read, then depth read
// of that ancestor); unless one node is an ancestor of the other, it then
// lifts both nodes together level by level on the two ancestor read ports.
// The result sits in an output register, so the next item is accepted while
// it waits; a query that finishes while an earlier result still waits holds
// in its output state until that result is taken. Node numbers of NODES or
// more act as node 0. The tables need no clearing after reset; nodes must be
// loaded parents-first before they are queried.
// ----------------------------------------------------------------------------
module lca_binary_lifting_engine import lcabl_pkg::*; #(
  parameter int NODES  = NODES_DEF,
  parameter int LEVELS = LEVELS_DEF
) (
  input logic         clk,
  input logic         rst_n,
  lcabl_in_if.sink    in_ch,
  lcabl_out_if.source out_ch
);

  anc_wr_t anc_wr;
  anc_rd_t anc_rd_a;
  anc_rd_t anc_rd_b;
  node_t   anc_q_a;
  node_t   anc_q_b;
  dep_wr_t dep_wr;
  node_t   dep_rd_a;
  node_t   dep_rd_b;
  depth_t  dep_q_a;
  depth_t  dep_q_b;

  // Sequencer
  lcabl_seq #(
    .NODES  (NODES),
    .LEVELS (LEVELS)
  ) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_func       (in_ch.func),
    .in_node_a     (in_ch.node_a),
    .in_node_b     (in_ch.node_b),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_lca_node  (out_ch.lca_node),
    .out_lca_depth (out_ch.lca_depth),
    .anc_wr        (anc_wr),
    .anc_rd_a      (anc_rd_a),
    .anc_rd_b      (anc_rd_b),
    .anc_q_a       (anc_q_a),
    .anc_q_b       (anc_q_b),
    .dep_wr        (dep_wr),
    .dep_rd_a      (dep_rd_a),
    .dep_rd_b      (dep_rd_b),
    .dep_q_a       (dep_q_a),
    .dep_q_b       (dep_q_b)
  );

  // Ancestor table
  lcabl_anc_mem #(
    .NODES  (NODES),
    .LEVELS (LEVELS)
  ) u_anc_mem (
    .clk  (clk),
    .wr   (anc_wr),
    .rd_a (anc_rd_a),
    .rd_b (anc_rd_b),
    .q_a  (anc_q_a),
    .q_b  (anc_q_b)
  );

  // Depth table
  lcabl_dep_mem #(
    .NODES (NODES)
  ) u_dep_mem (
    .clk  (clk),
    .wr   (dep_wr),
    .rd_a (dep_rd_a),
    .rd_b (dep_rd_b),
    .q_a  (dep_q_a),
    .q_b  (dep_q_b)
  );

endmodule

FILE: sv/lcabl_chk.sv
// ----------------------------------------------------------------------------
// lcabl_chk
// Port-level checks of the LCA engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "lca_binary_lifting_engine_defines.svh"

module lcabl_chk import lcabl_pkg::*; (
  input logic   clk,
  input logic   rst_n,
  input logic   in_valid,
  input logic   in_ready,
  input logic   in_func,
  input logic   out_valid,
  input logic   out_ready,
  input node_t  lca_node,
  input depth_t lca_depth
);

  logic in_acc;

  assign in_acc = in_valid && in_ready;

  // Hold a stalled result transaction
  `LCABL_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(lca_node) && $stable(lca_depth), "stalled result changed")

  // Busy right after a query transaction is taken
  `LCABL_ASSERT_NXT(a_busy_after_acc, clk, rst_n, in_acc && (in_func == FUNC_QUERY), !in_ready, "ready stayed high after accept")

  // No result may appear in the cycle after a transaction is taken
  `LCABL_ASSERT_NXT(a_no_early_result, clk, rst_n, in_acc, !$rose(out_valid), "result appeared too early")

  // A new result only rises while ready is high
  `LCABL_ASSERT_IMP(a_ready_result, clk, rst_n, $rose(out_valid), in_ready, "result pushed while busy")

endmodule

bind lca_binary_lifting_engine lcabl_chk u_lcabl_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_func   (in_ch.func),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .lca_node  (out_ch.lca_node),
  .lca_depth (out_ch.lca_depth)
);

FILE: tb/lca_binary_lifting_engine_tb.sv
// ----------------------------------------------------------------------------
// lca_binary_lifting_engine_tb
// Self-checking bench for the binary-lifting LCA engine. A short table of
// directed transactions covers the sentinel node, the extreme node numbers,
// forests, reloads and cycles. Random tree building and queries follow,
// including a full-length chain that drives the depth into saturation.
// Results are checked against typed rows' answers or a predictor with its
// own ancestor and depth tables. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module lca_binary_lifting_engine_tb;
  import lcabl_pkg::*;

  localparam int NODES       = NODES_DEF;
  localparam int LEVELS      = LEVELS_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DIR_ROWS    = 21;

  typedef struct packed {
    node_t  node;
    depth_t depth;
  } lca_res_t;

  typedef struct packed {
    logic   func;
    node_t  node_a;
    node_t  node_b;
    logic   typed;
    node_t  want_node;
    depth_t want_depth;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;

  lcabl_in_if  in_ch();
  lcabl_out_if out_ch();

  lca_binary_lifting_engine DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predicted tree state
  node_t    anc_mem [NODES][LEVELS] = '{default: '0};
  depth_t   depth_mem [NODES]       = '{default: '0};
  bit       node_loaded [NODES]     = '{default: 1'b0};
  node_t    loaded_list [$];
  lca_res_t lca_expected [$];

  int unsigned fail_count   = 0;
  int unsigned results_seen = 0;
  int unsigned cycle_count  = 0;
  int unsigned burst_left   = 0;

  // Receiver stall pattern
  int unsigned rx_mode      = 0;
  int unsigned rx_mode_left = 0;
  int unsigned rx_hold_left = 0;
  bit          rx_hold_done = 1'b0;

  // Directed transactions; typed rows carry their expected answer
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{FUNC_QUERY, 10'd0,    10'd0,    1'b1, 10'd0,    10'd0},
    '{FUNC_LOAD,  10'd1,    10'd0,    1'b0, 10'd0,    10'd0},
    '{FUNC_LOAD,  10'd1023, 10'd1,    1'b0, 10'd0,    10'd0},
    '{FUNC_LOAD,  10'd0,    10'd1023, 1'b0, 10'd0,    10'd0},
    '{FUNC_QUERY, 10'd0,    10'd1023, 1'b1, 10'd0,    10'd0},
    '{FUNC_QUERY, 10'd1023, 10'd0,    1'b1, 10'd0,    10'd0},
    '{FUNC_QUERY, 10'd1,    10'd1,    1'b1, 10'd1,    10'd1},
    '{FUNC_QUERY, 10'd1023, 10'd1023, 1'b1, 10'd1023, 10'd2},
    '{FUNC_LOAD,  10'd2,    10'd1,    1'b0, 10'd0,    10'd0},
    '{FUNC_LOAD,  10'd512,  10'd2,    1'b0, 10'd0,    10'd0},
    '{FUNC_LOAD,  10'd1022, 10'd512,  1'b0, 10'd0,    10'd0},
    '{FUNC_QUERY, 10'd1022, 10'd1023, 1'b0, 10'd0,    10'd0},
    '{FUNC_QUERY, 10'd512,  10'd1022, 1'b0, 10'd0,    10'd0},
    '{FUNC_QUERY, 10'd1022, 10'd1,    1'b0, 10'd0,    10'd0},
    '{FUNC_LOAD,  10'd3,    10'd0,    1'b0, 10'd0,    10'd0},
    '{FUNC_QUERY, 10'd3,    10'd1023, 1'b0, 10'd0,    10'd0},
    '{FUNC_LOAD,  10'd1023, 10'd1022, 1'b0, 10'd0,    10'd0},
    '{FUNC_QUERY, 10'd1023, 10'd512,  1'b0, 10'd0,    10'd0},
    '{FUNC_LOAD,  10'd1022, 10'd1023, 1'b0, 10'd0,    10'd0},
    '{FUNC_QUERY, 10'd1022, 10'd1023, 1'b0, 10'd0,    10'd0},
    '{FUNC_QUERY, 10'd1023, 10'd2,    1'b0, 10'd0,    10'd0}
  };

  // Clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Write a node's depth and all of its ancestor levels
  function automatic void tree_load(node_t n, node_t p);
    int unsigned d;
    node_t       mid;
    if (n == '0) return;
    d = int'(depth_mem[p]) + 1;
    if (d > DEPTH_MAX) d = DEPTH_MAX;
    depth_mem[n]  = depth_t'(d);
    anc_mem[n][0] = p;
    for (int i = 1; i < LEVELS; i++) begin
      mid           = anc_mem[n][i-1];
      anc_mem[n][i] = anc_mem[mid][i-1];
    end
  endfunction

  // Lift the deeper node, then both together
  function automatic node_t tree_lca(node_t a, node_t b);
    node_t x;
    node_t y;
    node_t t;
    node_t ux;
    node_t uy;
    x = a;
    y = b;
    if (depth_mem[x] < depth_mem[y]) begin
      t = x;
      x = y;
      y = t;
    end
    for (int i = LEVELS - 1; i >= 0; i--) begin
      ux = anc_mem[x][i];
      if (depth_mem[ux] >= depth_mem[y]) x = ux;
    end
    if (x == y) return x;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      ux = anc_mem[x][i];
      uy = anc_mem[y][i];
      if (ux != uy) begin
        x = ux;
        y = uy;
      end
    end
    return anc_mem[x][0];
  endfunction

  // Any loaded node, now and then the sentinel
  function automatic node_t pick_node();
    if (loaded_list.size() == 0 || $urandom_range(0, 15) == 0) return '0;
    return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
  endfunction

  // Offer one transaction, wait for acceptance, then update the prediction
  task automatic issue_item(logic f, node_t a, node_t b, logic typed = 1'b0,
                            node_t want_node = '0, depth_t want_depth = '0);
    int unsigned gap;
    lca_res_t    res;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid  <= 1'b1;
    in_ch.func   <= f;
    in_ch.node_a <= a;
    in_ch.node_b <= b;
    do @(posedge clk); while (!in_ch.ready);
    if (f == FUNC_LOAD) begin
      tree_load(a, b);
      if (a != '0 && !node_loaded[a]) begin
        node_loaded[a] = 1'b1;
        loaded_list.push_back(a);
      end
    end else begin
      res.node  = typed ? want_node : tree_lca(a, b);
      res.depth = typed ? want_depth : depth_mem[res.node];
      lca_expected.push_back(res);
    end
  endtask

  // Query two nodes; often one is an ancestor of the other
  task automatic rand_query();
    node_t x;
    node_t y;
    x = pick_node();
    if ($urandom_range(0, 3) == 0) begin
      y = x;
      repeat ($urandom_range(1, 8)) y = anc_mem[y][0];
    end else begin
      y = pick_node();
    end
    if ($urandom_range(0, 1) == 1) issue_item(FUNC_QUERY, x, y);
    else issue_item(FUNC_QUERY, y, x);
  endtask

  // Grow a forest parents-first, with queries, reloads and dropped loads
  task automatic tree_mix(int unsigned count);
    int unsigned r;
    node_t       n;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        issue_item(FUNC_LOAD, '0, node_t'($urandom_range(0, NODES - 1)));
      end else if (r < 10 || (r < 55 && loaded_list.size() >= NODES - 1)) begin
        issue_item(FUNC_LOAD, pick_node(), pick_node());
      end else if (r < 55) begin
        do n = node_t'($urandom_range(1, NODES - 1)); while (node_loaded[n]);
        issue_item(FUNC_LOAD, n, ($urandom_range(0, 9) == 0) ? node_t'(0) : pick_node());
      end else begin
        rand_query();
      end
    end
  endtask

  // Chain every node in random order, then close it into saturation
  task automatic deep_chain();
    node_t       order [NODES-1];
    node_t       t;
    int unsigned j;
    for (int i = 0; i < NODES - 1; i++) order[i] = node_t'(i + 1);
    for (int i = NODES - 2; i > 0; i--) begin
      j        = $urandom_range(0, i);
      t        = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (int i = 0; i < NODES - 1; i++) begin
      issue_item(FUNC_LOAD, order[i], (i == 0) ? node_t'(0) : order[i-1]);
      if ($urandom_range(0, 7) == 0) rand_query();
    end
    issue_item(FUNC_QUERY, order[NODES-2], order[0]);
    issue_item(FUNC_LOAD, order[0], order[NODES-2]);
    issue_item(FUNC_QUERY, order[0], order[NODES-2]);
    issue_item(FUNC_LOAD, order[511], order[0]);
    issue_item(FUNC_QUERY, order[511], order[NODES-2]);
    issue_item(FUNC_QUERY, order[700], order[511]);
    repeat (6) rand_query();
  endtask

  // Compare one result transaction with the oldest expectation
  task automatic check_result(node_t got_node, depth_t got_depth);
    lca_res_t want;
    if (lca_expected.size() == 0) begin
      $error("unexpected result: lca_node %0d, lca_depth %0d", got_node, got_depth);
      fail_count++;
      return;
    end
    want = lca_expected.pop_front();
    if (got_node !== want.node) begin
      $error("lca_node: expected %0d, got %0d", want.node, got_node);
      fail_count++;
    end
    if (got_depth !== want.depth) begin
      $error("lca_depth: expected %0d, got %0d", want.depth, got_depth);
      fail_count++;
    end
  endtask

  // Receiver: check accepted results, stall on its own pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        check_result(out_ch.lca_node, out_ch.lca_depth);
        results_seen++;
      end
      // hold off once for a long stretch so the engine backs up
      if (results_seen == 20 && !rx_hold_done) begin
        rx_hold_left = 500;
        rx_hold_done = 1'b1;
      end
      if (rx_mode_left == 0) begin
        rx_mode_left = $urandom_range(50, 400);
        rx_mode      = $urandom_range(0, 2);
      end
      rx_mode_left--;
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (rx_mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= ($urandom_range(0, 1) == 1);
          default: out_ch.ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("lca_binary_lifting_engine_tb: errors");
      $finish;
    end
  end

  // Stimulus
  initial begin
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.func   <= FUNC_LOAD;
    in_ch.node_a <= '0;
    in_ch.node_b <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      issue_item(dir_rows[i].func, dir_rows[i].node_a, dir_rows[i].node_b,
                 dir_rows[i].typed, dir_rows[i].want_node, dir_rows[i].want_depth);
    end

    tree_mix(120);
    deep_chain();
    tree_mix(80);
    in_ch.valid <= 1'b0;

    // drain, then leave room for anything stray
    while (lca_expected.size() != 0) @(posedge clk);
    repeat (3 * LEVELS + 20) @(posedge clk);

    if (fail_count == 0) begin
      $display("lca_binary_lifting_engine_tb: clean");
    end else begin
      $display("lca_binary_lifting_engine_tb: errors");
    end
    $finish;
  end

endmodule
